// File: rtl/core/fatl_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and saturation helpers for the font atlas text layout block
// no dependencies

package fatl_pkg;

	localparam int GLYPH_TABLE_DEPTH = 256;
	localparam int GLYPH_ADDR_W      = $clog2(GLYPH_TABLE_DEPTH);
	localparam logic [8:0] GLYPH_DEPTH_LIM = 9'(GLYPH_TABLE_DEPTH);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	// quotient bits resolved per cycle in the atlas row divider
	localparam int DIV_BITS_PER_STEP = 4;
	localparam int DIV_STEPS         = 8 / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam int SCR_W = 34;
	localparam logic signed [SCR_W-1:0] SCREEN_MAX = 34'sd524287;
	localparam logic signed [SCR_W-1:0] SCREEN_MIN = -34'sd524288;

	localparam int TEX_W = 19;
	localparam logic signed [TEX_W-1:0] TEXEL_MAX = 19'sd16383;

	typedef enum logic {
		OP_LAYOUT      = 1'b0,
		OP_TABLE_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CELL_WIDTH    = 3'd0,
		REG_CELL_HEIGHT   = 3'd1,
		REG_ATLAS_COLUMNS = 3'd2,
		REG_ATLAS_ROWS    = 3'd3,
		REG_HSPACING      = 3'd4,
		REG_VSPACING      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]        index;
		logic              valid;
		logic signed [7:0] offset;
	} glyph_entry_t;

	function automatic logic signed [19:0] sat_screen(input logic signed [SCR_W-1:0] v);
		logic signed [19:0] r;
		if (v > SCREEN_MAX) begin
			r = SCREEN_MAX[19:0];
		end else if (v < SCREEN_MIN) begin
			r = SCREEN_MIN[19:0];
		end else begin
			r = v[19:0];
		end
		return r;
	endfunction

	function automatic logic [13:0] sat_texel(input logic signed [TEX_W-1:0] v);
		logic [13:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > TEXEL_MAX) begin
			r = TEXEL_MAX[13:0];
		end else begin
			r = v[13:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/fatl_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: command items in, quad items out, register writes
// depends on fatl_pkg

interface fatl_cmd_if import fatl_pkg::*;;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [7:0]        char_code;
	logic              first_of_string;
	logic [11:0]       origin_x;
	logic [11:0]       origin_y;
	logic [3:0]        size_factor;
	logic [7:0]        glyph_index;
	logic              glyph_valid;
	logic signed [7:0] glyph_offset;

	modport source (
		output valid, opcode, char_code, first_of_string, origin_x, origin_y,
		size_factor, glyph_index, glyph_valid, glyph_offset,
		input  ready
	);
	modport sink (
		input  valid, opcode, char_code, first_of_string, origin_x, origin_y,
		size_factor, glyph_index, glyph_valid, glyph_offset,
		output ready
	);
endinterface

interface fatl_quad_if import fatl_pkg::*;;
	logic               valid;
	logic               ready;
	logic signed [19:0] screen_left;
	logic signed [19:0] screen_top;
	logic signed [19:0] screen_right;
	logic signed [19:0] screen_bottom;
	logic [13:0]        texel_left;
	logic [13:0]        texel_top;
	logic [13:0]        texel_right;
	logic [13:0]        texel_bottom;
	logic               glyph_found;

	modport source (
		output valid, screen_left, screen_top, screen_right, screen_bottom,
		texel_left, texel_top, texel_right, texel_bottom, glyph_found,
		input  ready
	);
	modport sink (
		input  valid, screen_left, screen_top, screen_right, screen_bottom,
		texel_left, texel_top, texel_right, texel_bottom, glyph_found,
		output ready
	);
endinterface

interface fatl_cfg_if import fatl_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/font_atlas_text_layout.sv
`timescale 1ns / 1ps
// Bitmap font atlas text layout: turns character items into screen and atlas quads.
//
// Channels: cmd (sink) takes one item per character or glyph table write; quad
// (source) gives one quad per laid-out character other than newline; cfg (sink)
// writes the six layout registers, always ready, meant to be used while idle.
// A table write is done in the cycle it is taken; a newline only moves the
// line and column counts. Both let the next item in on the following cycle.
// A laid-out character reads the glyph table memory, runs the multiply
// pipeline for the screen corners while a 4-bit-per-cycle divider finds the
// atlas row and column, then works out the texel corners and loads the quad
// into the output register. cmd is not ready while a character is in flight,
// so the next item is taken only once the quad has been loaded.
// The output register holds a quad while quad.ready is low; a following item
// is still taken and computed, and then waits until the register frees up.
// Reset clears the counts, marks every table entry unwritten (reads as index
// 0, invalid, zero offset) and loads the default registers; no clearing pass.
// Depends on fatl_pkg and fatl_if.

module font_atlas_text_layout import fatl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fatl_cmd_if.sink     cmd,
	fatl_quad_if.source  quad,
	fatl_cfg_if.sink     cfg
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOOK = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_TEX  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// layout registers
	logic [7:0]        cell_width_q;
	logic [7:0]        cell_height_q;
	logic [6:0]        atlas_columns_q;
	logic [6:0]        atlas_rows_q;
	logic signed [6:0] hspacing_q;
	logic signed [6:0] vspacing_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q    <= 8'd16;
			cell_height_q   <= 8'd16;
			atlas_columns_q <= 7'd16;
			atlas_rows_q    <= 7'd6;
			hspacing_q      <= 7'sd3;
			vspacing_q      <= 7'sd5;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_CELL_WIDTH:    cell_width_q    <= cfg.data;
				REG_CELL_HEIGHT:   cell_height_q   <= cfg.data;
				REG_ATLAS_COLUMNS: atlas_columns_q <= cfg.data[6:0];
				REG_ATLAS_ROWS:    atlas_rows_q    <= cfg.data[6:0];
				REG_HSPACING:      hspacing_q      <= cfg.data[6:0];
				REG_VSPACING:      vspacing_q      <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// command decode
	logic                    cmd_acc;
	logic                    is_write;
	logic                    in_range;
	logic                    is_newline;
	logic                    tbl_we;
	logic                    lay_acc;
	logic                    start;
	logic [GLYPH_ADDR_W-1:0] addr;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign is_write   = (opcode_t'(cmd.opcode) == OP_TABLE_WRITE);
	assign in_range   = ({1'b0, cmd.char_code} < GLYPH_DEPTH_LIM);
	assign is_newline = (cmd.char_code == NEWLINE_CODE);
	assign addr       = cmd.char_code[GLYPH_ADDR_W-1:0];
	assign tbl_we     = cmd_acc && is_write && in_range;
	assign lay_acc    = cmd_acc && !is_write;
	assign start      = lay_acc && !is_newline;

	// glyph table memory, entries that were never written read as zero
	glyph_entry_t                 glyph_mem [GLYPH_TABLE_DEPTH];
	glyph_entry_t                 rd_entry_q;
	logic [GLYPH_TABLE_DEPTH-1:0] written_q;
	logic                         rd_written_q;
	glyph_entry_t                 ent;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			glyph_mem[addr] <= '{index: cmd.glyph_index, valid: cmd.glyph_valid,
				offset: cmd.glyph_offset};
		end
		if (start) begin
			rd_entry_q <= glyph_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (tbl_we) begin
				written_q[addr] <= 1'b1;
			end
			if (start) begin
				rd_written_q <= written_q[addr] && in_range;
			end
		end
	end

	assign ent = rd_written_q ? rd_entry_q : '0;

	// column and line counts
	logic [15:0] column_q;
	logic [15:0] line_q;
	logic [15:0] col_eff;
	logic [15:0] line_eff;

	assign col_eff  = cmd.first_of_string ? '0 : column_q;
	assign line_eff = cmd.first_of_string ? '0 : line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			line_q   <= '0;
		end else if (lay_acc) begin
			if (is_newline) begin
				line_q   <= line_eff + 16'd1;
				column_q <= '0;
			end else begin
				line_q   <= line_eff;
				column_q <= col_eff + 16'd1;
			end
		end
	end

	// held item fields
	logic [15:0] col_use_q;
	logic [15:0] line_use_q;
	logic [11:0] ox_q;
	logic [11:0] oy_q;
	logic [3:0]  scale_q;

	always_ff @(posedge clk) begin
		if (start) begin
			col_use_q  <= col_eff;
			line_use_q <= line_eff;
			ox_q       <= cmd.origin_x;
			oy_q       <= cmd.origin_y;
			scale_q    <= cmd.size_factor;
		end
	end

	// screen pipeline, registered in stages s1, s2 and s3 after the table read
	logic signed [9:0]  pitch_x;
	logic signed [9:0]  pitch_y;
	logic signed [14:0] px_s1;
	logic signed [14:0] py_s1;
	logic [11:0]        cws_s1;
	logic [11:0]        chs_s1;
	logic signed [7:0]  off_s1;
	logic signed [31:0] colpx_s2;
	logic signed [31:0] linepy_s2;
	logic [11:0]        cws_s2;
	logic [11:0]        chs_s2;
	logic signed [7:0]  off_s2;
	logic signed [32:0] left_s3;
	logic signed [32:0] top_s3;
	logic [11:0]        cws_s3;
	logic [11:0]        chs_s3;

	assign pitch_x = $signed({2'b00, cell_width_q}) + $signed({{3{hspacing_q[6]}}, hspacing_q});
	assign pitch_y = $signed({2'b00, cell_height_q}) + $signed({{3{vspacing_q[6]}}, vspacing_q});

	always_ff @(posedge clk) begin
		px_s1     <= pitch_x * $signed({1'b0, scale_q});
		py_s1     <= pitch_y * $signed({1'b0, scale_q});
		cws_s1    <= cell_width_q * scale_q;
		chs_s1    <= cell_height_q * scale_q;
		off_s1    <= ent.offset;

		colpx_s2  <= $signed({1'b0, col_use_q}) * px_s1;
		linepy_s2 <= $signed({1'b0, line_use_q}) * py_s1;
		cws_s2    <= cws_s1;
		chs_s2    <= chs_s1;
		off_s2    <= off_s1;

		left_s3   <= $signed({21'b0, ox_q}) + $signed({colpx_s2[31], colpx_s2});
		top_s3    <= $signed({21'b0, oy_q}) + $signed({linepy_s2[31], linepy_s2})
			+ $signed({{25{off_s2[7]}}, off_s2});
		cws_s3    <= cws_s2;
		chs_s3    <= chs_s2;
	end

	// atlas row divider: row = index / columns, remainder is the column
	logic [6:0]           cols_q;
	logic [7:0]           quo_q;
	logic [6:0]           rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [7:0]           quo_nxt;
	logic [6:0]           rem_nxt;

	always_comb begin
		logic [7:0] t;
		logic [7:0] q;
		logic [6:0] r;
		q = quo_q;
		r = rem_q;
		t = '0;
		for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
			t = {r, q[7]};
			q = {q[6:0], 1'b0};
			if (t >= {1'b0, cols_q}) begin
				t    = t - {1'b0, cols_q};
				q[0] = 1'b1;
			end
			r = t[6:0];
		end
		quo_nxt = q;
		rem_nxt = r;
	end

	// texel products
	logic [14:0]        tl_q;
	logic signed [17:0] tt_q;
	logic signed [8:0]  row_diff;

	assign row_diff = $signed({2'b00, atlas_rows_q}) - $signed({1'b0, quo_q});

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOOK: begin
				quo_q  <= ent.index;
				rem_q  <= '0;
				cols_q <= (atlas_columns_q == '0) ? 7'd1 : atlas_columns_q;
			end
			ST_DIV: begin
				quo_q <= quo_nxt;
				rem_q <= rem_nxt;
			end
			ST_TEX: begin
				tl_q <= rem_q * cell_width_q;
				tt_q <= row_diff * $signed({1'b0, cell_height_q});
			end
			default: ;
		endcase
	end

	// result assembly and output register
	logic               load_out;
	logic               out_vld_q;
	logic signed [19:0] sl_q;
	logic signed [19:0] st_q;
	logic signed [19:0] sr_q;
	logic signed [19:0] sb_q;
	logic [13:0]        tl_out_q;
	logic [13:0]        tt_out_q;
	logic [13:0]        tr_out_q;
	logic [13:0]        tb_out_q;
	logic               found_q;
	logic [TEX_W-1:0]   tl_ext;
	logic [TEX_W-1:0]   tt_ext;
	logic [TEX_W-1:0]   cw_ext;
	logic [TEX_W-1:0]   ch_ext;

	assign load_out = (state_q == ST_FIN) && (!out_vld_q || quad.ready);
	assign tl_ext   = {4'b0, tl_q};
	assign tt_ext   = {tt_q[17], tt_q};
	assign cw_ext   = {11'b0, cell_width_q};
	assign ch_ext   = {11'b0, cell_height_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			sl_q <= sat_screen({left_s3[32], left_s3});
			st_q <= sat_screen({top_s3[32], top_s3});
			sr_q <= sat_screen($signed({left_s3[32], left_s3}) + $signed({22'b0, cws_s3}));
			sb_q <= sat_screen($signed({top_s3[32], top_s3}) + $signed({22'b0, chs_s3}));
			found_q <= ent.valid;
			if (ent.valid) begin
				tl_out_q <= sat_texel(tl_ext);
				tt_out_q <= sat_texel(tt_ext);
				tr_out_q <= sat_texel(tl_ext + cw_ext);
				tb_out_q <= sat_texel(tt_ext - ch_ext);
			end else begin
				tl_out_q <= '0;
				tt_out_q <= '0;
				tr_out_q <= '0;
				tb_out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (quad.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign quad.valid         = out_vld_q;
	assign quad.screen_left   = sl_q;
	assign quad.screen_top    = st_q;
	assign quad.screen_right  = sr_q;
	assign quad.screen_bottom = sb_q;
	assign quad.texel_left    = tl_out_q;
	assign quad.texel_top     = tt_out_q;
	assign quad.texel_right   = tr_out_q;
	assign quad.texel_bottom  = tb_out_q;
	assign quad.glyph_found   = found_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_TEX;
					end
				end
				ST_TEX: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
